>>> rtl/p80_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_pkg: shared types, constants and functions for the 80-bit-key
// lightweight block cipher.
// S-box layers, bit permutations and key-schedule steps.
// ----------------------------------------------------------------------------
package p80_pkg;

   localparam int NumRounds = 31;
   localparam int CtrWidth  = 5;
   localparam int KeyWidth  = 80;
   localparam int BlkWidth  = 64;

   // CSR register indexes
   localparam logic CSR_KEY_UPPER = 1'b0;
   localparam logic CSR_KEY_LOWER = 1'b1;

   // Control word from the sequencer to the round unit
   typedef struct packed {
      logic                  data_inv;   // inverse round (decrypt)
      logic                  key_inv;    // key schedule runs backward
      logic [CtrWidth-1:0]   ctr;        // round counter XORed at bits 19..15
   } p80_ctl_type;

   function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;  4'h1: y = 4'h5;  4'h2: y = 4'h6;  4'h3: y = 4'hB;
         4'h4: y = 4'h9;  4'h5: y = 4'h0;  4'h6: y = 4'hA;  4'h7: y = 4'hD;
         4'h8: y = 4'h3;  4'h9: y = 4'hE;  4'hA: y = 4'hF;  4'hB: y = 4'h8;
         4'hC: y = 4'h4;  4'hD: y = 4'h7;  4'hE: y = 4'h1;  4'hF: y = 4'h2;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

   function automatic logic [3:0] sbox_inv(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'h5;  4'h1: y = 4'hE;  4'h2: y = 4'hF;  4'h3: y = 4'h8;
         4'h4: y = 4'hC;  4'h5: y = 4'h1;  4'h6: y = 4'h2;  4'h7: y = 4'hD;
         4'h8: y = 4'hB;  4'h9: y = 4'h4;  4'hA: y = 4'h6;  4'hB: y = 4'h3;
         4'hC: y = 4'h0;  4'hD: y = 4'h7;  4'hE: y = 4'h9;  4'hF: y = 4'hA;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

   // 16 parallel S-boxes
   function automatic logic [BlkWidth-1:0] sub_layer(input logic [BlkWidth-1:0] s,
                                                     input logic inv);
      logic [BlkWidth-1:0] r;
      r = '0;
      for (int n = 0; n < BlkWidth / 4; n++) begin
         r[4*n +: 4] = inv ? sbox_inv(s[4*n +: 4]) : sbox_fwd(s[4*n +: 4]);
      end
      return r;
   endfunction

   // bit i moves to (i mod 4) * 16 + i / 4
   function automatic logic [BlkWidth-1:0] perm_fwd(input logic [BlkWidth-1:0] s);
      logic [BlkWidth-1:0] r;
      r = '0;
      for (int i = 0; i < BlkWidth; i++) begin
         r[(i % 4) * 16 + i / 4] = s[i];
      end
      return r;
   endfunction

   function automatic logic [BlkWidth-1:0] perm_inv(input logic [BlkWidth-1:0] s);
      logic [BlkWidth-1:0] r;
      r = '0;
      for (int i = 0; i < BlkWidth; i++) begin
         r[i] = s[(i % 4) * 16 + i / 4];
      end
      return r;
   endfunction

   // forward step: rotate left by 61, S-box on top nibble, counter at 19..15
   function automatic logic [KeyWidth-1:0] key_fwd(input logic [KeyWidth-1:0] k,
                                                   input logic [CtrWidth-1:0] ctr);
      logic [KeyWidth-1:0] r;
      r = {k[18:0], k[79:19]};
      r[79:76] = sbox_fwd(r[79:76]);
      r[19:15] = r[19:15] ^ ctr;
      return r;
   endfunction

   // backward step: exact inverse of key_fwd
   function automatic logic [KeyWidth-1:0] key_inv(input logic [KeyWidth-1:0] k,
                                                   input logic [CtrWidth-1:0] ctr);
      logic [KeyWidth-1:0] t;
      t = k;
      t[19:15] = t[19:15] ^ ctr;
      t[79:76] = sbox_inv(t[79:76]);
      return {t[60:0], t[79:61]};
   endfunction

endpackage

>>> rtl/p80_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p80_round: shared round unit
// One cipher round (forward or inverse) and one key-schedule step
// (forward or backward), reused every cycle by the sequencer.
// ----------------------------------------------------------------------------
module p80_round (
   input  logic [p80_pkg::BlkWidth-1:0] data,
   input  logic [p80_pkg::KeyWidth-1:0] key,
   input  p80_pkg::p80_ctl_type         ctl,
   output logic [p80_pkg::BlkWidth-1:0] data_next,
   output logic [p80_pkg::KeyWidth-1:0] key_next
);

   logic [p80_pkg::BlkWidth-1:0] fwd_data;
   logic [p80_pkg::BlkWidth-1:0] inv_data;

   // key schedule step
   assign key_next = ctl.key_inv ? p80_pkg::key_inv(key, ctl.ctr)
                                 : p80_pkg::key_fwd(key, ctl.ctr);

   // forward round uses the current round key, inverse round the previous one
   assign fwd_data = p80_pkg::perm_fwd(p80_pkg::sub_layer(data ^ key[79:16], 1'b0));
   assign inv_data = p80_pkg::sub_layer(p80_pkg::perm_inv(data), 1'b1) ^ key_next[79:16];

   assign data_next = ctl.data_inv ? inv_data : fwd_data;

endmodule

>>> rtl/present80_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_cipher_unit: 80-bit-key lightweight block cipher
// Encrypts or decrypts one 64-bit block per transfer with a shared round unit.
// ----------------------------------------------------------------------------
// One round unit does all the work, one round or one key-schedule step per
// cycle. Encryption runs 31 rounds and then a delivery state that loads the
// result register; the next input transfer is taken once the block is back
// in idle. Decryption first takes 31 forward key-schedule steps to reach
// the last round key. It then runs 31 inverse rounds while stepping the
// schedule backward, followed by the delivery state. The input is stalled
// from each input transfer until the block is idle again, so a new block is
// taken only after the last one is delivered. A result waiting in the output
// register does not hold off the next input transfer. A finished block,
// however, waits until the output register has been taken, and the input
// stays stalled while it waits. The user must write the key registers
// through the CSR port only while the block is idle (index 0: key bits
// 79..64, index 1: key bits 63..0); the block itself does not enforce it.
// The cipher never changes them.
// ----------------------------------------------------------------------------
module present80_block_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_block_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   // configuration writes
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCHED = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [p80_pkg::CtrWidth-1:0] CtrLast  = p80_pkg::CtrWidth'(p80_pkg::NumRounds);
   localparam logic [p80_pkg::CtrWidth-1:0] CtrFirst = p80_pkg::CtrWidth'(1);

   logic [15:0]                   key_upper_ff, key_upper_in;
   logic [63:0]                   key_lower_ff, key_lower_in;
   logic [1:0]                    state_ff, state_in;
   logic [p80_pkg::CtrWidth-1:0]  ctr_ff, ctr_in;
   logic                          dec_ff, dec_in;
   logic [p80_pkg::BlkWidth-1:0]  data_ff, data_in;
   logic [p80_pkg::KeyWidth-1:0]  key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [p80_pkg::BlkWidth-1:0]  rsp_data_ff, rsp_data_in;

   p80_pkg::p80_ctl_type          ctl;
   logic [p80_pkg::BlkWidth-1:0]  unit_data;
   logic [p80_pkg::KeyWidth-1:0]  unit_key;
   logic                          req_xfer;
   logic                          out_free;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_data_ff;

   // round unit control: schedule phase always steps forward
   always_comb begin
      ctl.ctr      = ctr_ff;
      ctl.data_inv = dec_ff;
      ctl.key_inv  = dec_ff && (state_ff == ST_ROUND);
   end

   p80_round u_round (
      .data      (data_ff),
      .key       (key_ff),
      .ctl       (ctl),
      .data_next (unit_data),
      .key_next  (unit_key)
   );

   // key registers
   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      if (csr_write) begin
         case (csr_index)
            p80_pkg::CSR_KEY_UPPER: key_upper_in = csr_wdata[15:0];
            p80_pkg::CSR_KEY_LOWER: key_lower_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      dec_in       = dec_ff;
      data_in      = data_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               data_in  = req_block_in;
               key_in   = {key_upper_ff, key_lower_ff};
               dec_in   = req_type;
               ctr_in   = CtrFirst;
               state_in = req_type ? ST_SCHED : ST_ROUND;
            end
         end
         ST_SCHED: begin
            key_in = unit_key;
            if (ctr_ff == CtrLast) begin
               // whitening with the last round key
               data_in  = data_ff ^ unit_key[79:16];
               state_in = ST_ROUND;
            end else begin
               ctr_in = ctr_ff + CtrFirst;
            end
         end
         ST_ROUND: begin
            data_in = unit_data;
            key_in  = unit_key;
            if (dec_ff) begin
               if (ctr_ff == CtrFirst) begin
                  state_in = ST_DONE;
               end else begin
                  ctr_in = ctr_ff - CtrFirst;
               end
            end else begin
               if (ctr_ff == CtrLast) begin
                  state_in = ST_DONE;
               end else begin
                  ctr_in = ctr_ff + CtrFirst;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dec_ff ? data_ff : (data_ff ^ key_ff[79:16]);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ctr_ff      <= ctr_in;
      dec_ff      <= dec_in;
      data_ff     <= data_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/present80_block_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_cipher_checker: result checker for the PRESENT-80 unit
// Follows key writes and request transfers, computes each expected cipher
// block and compares it with the response transfers in order.
// ----------------------------------------------------------------------------
module present80_block_cipher_checker
   import p80_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_block_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_block_out,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        drain_done,
   output int          fail_count,
   output int          pending_results
);

   // S-box tables, entry n in nibble n
   localparam logic [63:0] SBOX_ENC = 64'h21748FE3DA09B65C;
   localparam logic [63:0] SBOX_DEC = 64'hA970364BD21C8FE5;

   logic [KeyWidth-1:0] cipher_key;
   logic [BlkWidth-1:0] expected_blocks[$];
   logic [BlkWidth-1:0] expected_now;
   int                  error_count = 0;
   bit                  leftover_reported = 1'b0;

   assign fail_count = error_count;

   task automatic report_mismatch(input string detail);
      $display("[%0t] transfer mismatch: %s", $time, detail);
      error_count++;
   endtask

   function automatic logic [63:0] substitute(input logic [63:0] s, input logic [63:0] tab);
      logic [63:0] r;
      logic [3:0]  nib;
      for (int n = 0; n < 16; n++) begin
         nib = s[4*n +: 4];
         r[4*n +: 4] = tab[4*nib +: 4];
      end
      return r;
   endfunction

   // bit {hi, lo} of the index swaps its two low bits to the top
   function automatic logic [63:0] scatter_bits(input logic [63:0] s);
      logic [63:0] r;
      logic [5:0]  src;
      for (int i = 0; i < 64; i++) begin
         src = 6'(i);
         r[{src[1:0], src[5:2]}] = s[src];
      end
      return r;
   endfunction

   function automatic logic [63:0] gather_bits(input logic [63:0] s);
      logic [63:0] r;
      logic [5:0]  dst;
      for (int i = 0; i < 64; i++) begin
         dst = 6'(i);
         r[dst] = s[{dst[1:0], dst[5:2]}];
      end
      return r;
   endfunction

   // one schedule step: rotate right by 19, S-box on the top nibble, counter in
   function automatic logic [79:0] next_schedule(input logic [79:0] k, input logic [4:0] ctr);
      logic [79:0] r;
      r = {k[18:0], k[79:19]};
      r[79:76] = SBOX_ENC[4*r[79:76] +: 4];
      r[19:15] = r[19:15] ^ ctr;
      return r;
   endfunction

   function automatic logic [63:0] cipher_block(input logic [79:0] key, input logic decrypt,
                                                input logic [63:0] blk);
      logic [63:0] round_keys [0:NumRounds];
      logic [79:0] k;
      logic [63:0] s;
      k = key;
      for (int r = 0; r <= NumRounds; r++) begin
         round_keys[r] = k[79:16];
         if (r < NumRounds) k = next_schedule(k, 5'(r + 1));
      end
      s = blk;
      if (!decrypt) begin
         for (int r = 0; r < NumRounds; r++) begin
            s = scatter_bits(substitute(s ^ round_keys[r], SBOX_ENC));
         end
         s = s ^ round_keys[NumRounds];
      end else begin
         s = s ^ round_keys[NumRounds];
         for (int r = NumRounds; r > 0; r--) begin
            s = substitute(gather_bits(s), SBOX_DEC) ^ round_keys[r-1];
         end
      end
      return s;
   endfunction

   // follow key writes, queue expectations, compare responses
   always @(posedge clock) begin
      if (reset) begin
         cipher_key = '0;
         expected_blocks.delete();
         pending_results <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_KEY_UPPER) cipher_key[79:64] = csr_wdata[15:0];
            else if (csr_index == CSR_KEY_LOWER) cipher_key[63:0] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            expected_blocks.push_back(cipher_block(cipher_key, req_type, req_block_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", rsp_block_out));
            end else begin
               expected_now = expected_blocks.pop_front();
               if (rsp_block_out !== expected_now) begin
                  report_mismatch($sformatf("block_out expected %h, got %h",
                                            expected_now, rsp_block_out));
               end
            end
         end
         if (drain_done && !leftover_reported && expected_blocks.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
            leftover_reported = 1'b1;
         end
         pending_results <= expected_blocks.size();
      end
   end

endmodule

>>> tb/present80_block_cipher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_cipher_unit_test: testbench top for the PRESENT-80 unit
// Loads a series of keys, sends directed and random encrypt and decrypt
// transfers with bursty input and a stalling receiver, and gives the verdict.
// ----------------------------------------------------------------------------
module present80_block_cipher_unit_test;
   import p80_pkg::*;

   localparam logic DIR_ENCRYPT   = 1'b0;
   localparam logic DIR_DECRYPT   = 1'b1;
   localparam int   IdleLimit     = 2000;
   localparam int   HoldCycles    = 300;
   localparam int   RandomPhases  = 12;
   localparam int   ItemsPerPhase = 70;
   localparam int   DrainCycles   = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [63:0] req_block_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_block_out;
   logic        csr_write;
   logic        csr_index;
   logic [63:0] csr_wdata;
   logic        drain_done;
   int          fail_count;
   int          pending_results;

   bit          hold_off_req = 1'b0;
   int          burst_left   = 0;
   int          quiet_cycles = 0;
   int          encrypt_count = 0;
   int          decrypt_count = 0;
   int          key_settings  = 0;
   int          results_seen  = 0;

   always #1 clock = ~clock;

   present80_block_cipher_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   present80_block_cipher_checker cipher_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_block_in    (req_block_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_block_out   (rsp_block_out),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .drain_done      (drain_done),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // watchdog: ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) results_seen <= results_seen + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("watchdog: no transfer for %0d cycles", IdleLimit);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver: random stall modes and patterns, plus one long hold-off
   initial begin
      int          mode;
      int          cycle;
      logic [15:0] pattern;
      mode  = 0;
      cycle = 0;
      pattern = '0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            repeat (HoldCycles) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         if (cycle % 64 == 0) begin
            mode    = $urandom_range(0, 3);
            pattern = 16'($urandom);
         end
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= pattern[cycle % 16];
         endcase
         cycle++;
      end
   end

   // one request transfer; valid stays high inside a burst
   task automatic send_block(input logic dir, input logic [63:0] blk);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7:       gap = $urandom_range(1, 4);
            default:       gap = $urandom_range(5, 70);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid    <= 1'b1;
      req_type     <= dir;
      req_block_in <= blk;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (dir == DIR_DECRYPT) decrypt_count++;
      else encrypt_count++;
   endtask

   // stop sending and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // upper register gets random junk above bit 15 to check the masking
   task automatic load_key(input logic [79:0] key);
      logic [63:0] upper_word;
      upper_word = {$urandom, $urandom};
      upper_word[15:0] = key[79:64];
      write_reg(CSR_KEY_UPPER, upper_word);
      write_reg(CSR_KEY_LOWER, key[63:0]);
      csr_write <= 1'b0;
      key_settings++;
   endtask

   function automatic logic [63:0] random_block();
      logic [63:0] blk;
      case ($urandom_range(0, 7))
         0:       blk = $urandom_range(0, 1) ? '1 : '0;
         1:       blk = 64'h1 << $urandom_range(0, 63);
         2:       blk = {16{4'($urandom)}};
         default: blk = {$urandom, $urandom};
      endcase
      return blk;
   endfunction

   function automatic logic [79:0] random_key();
      logic [79:0] key;
      case ($urandom_range(0, 5))
         0:       key = '0;
         1:       key = '1;
         default: key = {16'($urandom), $urandom, $urandom};
      endcase
      return key;
   endfunction

   // stimulus
   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_type     <= DIR_ENCRYPT;
      req_block_in <= '0;
      csr_write    <= 1'b0;
      csr_index    <= CSR_KEY_UPPER;
      csr_wdata    <= '0;
      drain_done   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // key still at its reset value of zero
      send_block(DIR_ENCRYPT, '0);
      send_block(DIR_ENCRYPT, '1);
      send_block(DIR_DECRYPT, '0);
      send_block(DIR_DECRYPT, '1);
      settle();

      // all-ones key
      load_key('1);
      send_block(DIR_ENCRYPT, '0);
      send_block(DIR_DECRYPT, '1);
      send_block(DIR_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
      send_block(DIR_DECRYPT, 64'h5555_5555_5555_5555);
      send_block(DIR_ENCRYPT, 64'h0000_0000_0000_0001);
      send_block(DIR_DECRYPT, 64'h8000_0000_0000_0000);
      settle();

      // only one half of the key set
      load_key({16'hFFFF, 64'h0});
      send_block(DIR_ENCRYPT, '1);
      send_block(DIR_DECRYPT, '0);
      send_block(DIR_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      settle();
      load_key({16'h0000, 64'hFFFF_FFFF_FFFF_FFFF});
      send_block(DIR_DECRYPT, 64'hFEDC_BA98_7654_3210);
      send_block(DIR_ENCRYPT, 64'h8000_0000_0000_0000);
      send_block(DIR_DECRYPT, 64'h0000_0000_0000_0001);
      settle();

      // back to an all-zero key after a nonzero one
      load_key('0);
      send_block(DIR_ENCRYPT, '0);
      send_block(DIR_DECRYPT, 64'h5579_C138_7B22_8445);
      settle();

      // random phases, each under its own key
      for (int p = 0; p < RandomPhases; p++) begin
         load_key(random_key());
         if (p == 3) hold_off_req = 1'b1;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_block($urandom_range(0, 1) ? DIR_DECRYPT : DIR_ENCRYPT, random_block());
         end
         settle();
      end

      // let any stray result show up, then check for leftovers
      repeat (DrainCycles) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("covered %0d encryptions and %0d decryptions under %0d key settings",
               encrypt_count, decrypt_count, key_settings);
      $display("%0d results compared, one receiver hold-off of %0d cycles",
               results_seen, HoldCycles);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
